@@ rtl/core/cobo_pkg.sv @@
`timescale 1ns / 1ps

package cobo_pkg;

  localparam int COORD_BITS_DEF   = 24;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Number of entries in the arctangent table; steps beyond it are skipped.
  localparam int ATAN_COUNT = 24;

  // Width of the CORDIC datapath (Q2.30 plus headroom) and of cos/sin in Q24.
  localparam int CORD_W = 34;
  localparam int CS_W   = 27;

  // Gain-compensated starting x in Q2.30 and 2*pi scaled for a Q2.30 radian result.
  localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [63:0]       TURN_TO_RAD = 64'sd1686629713;

  localparam logic [63:0] SQ_SAT = 64'h4000_0000_0000_0000;

  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_REG_DISTANCE_BIAS = 1'b0;

  function automatic logic signed [CORD_W-1:0] atan_q30(input int unsigned idx);
    logic signed [CORD_W-1:0] v;
    case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/cobo_sincos.sv @@
`timescale 1ns / 1ps

module cobo_sincos #(
  parameter int ANGLE_BITS   = cobo_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = cobo_pkg::CORDIC_STEPS_DEF,
  parameter int SIDE_W       = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [ANGLE_BITS-1:0]         heading,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_valid,
  output logic signed [cobo_pkg::CS_W-1:0] cos_q,
  output logic signed [cobo_pkg::CS_W-1:0] sin_q,
  output logic [SIDE_W-1:0]             side_out
);

  localparam int CW = cobo_pkg::CORD_W;
  localparam int NS = (CORDIC_STEPS < cobo_pkg::ATAN_COUNT) ? CORDIC_STEPS
                                                            : cobo_pkg::ATAN_COUNT;

  // Quarter-turn reduction stage.
  logic [31:0]        phase;
  logic [31:0]        phase_rnd;
  logic [1:0]         quad;
  logic [31:0]        resid;
  logic               a_v_r;
  logic [1:0]         a_q_r;
  logic signed [31:0] a_res_r;
  logic [SIDE_W-1:0]  a_side_r;

  assign phase     = {heading, {(32 - ANGLE_BITS){1'b0}}};
  assign phase_rnd = phase + 32'h2000_0000;
  assign quad      = phase_rnd[31:30];
  assign resid     = phase - {quad, 30'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q_r    <= quad;
      a_res_r  <= $signed(resid);
      a_side_r <= side_in;
    end
  end

  // CORDIC rotation stages; stage 0 holds the residual angle in radians.
  logic                 v_r    [0:NS];
  logic signed [CW-1:0] x_r    [0:NS];
  logic signed [CW-1:0] y_r    [0:NS];
  logic signed [CW-1:0] z_r    [0:NS];
  logic [1:0]           q_r    [0:NS];
  logic [SIDE_W-1:0]    side_r [0:NS];
  logic signed [63:0]   z_prod;

  assign z_prod = 64'(a_res_r) * cobo_pkg::TURN_TO_RAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= cobo_pkg::CORDIC_X0;
      y_r[0]    <= '0;
      z_r[0]    <= z_prod[30 +: CW];
      q_r[0]    <= a_q_r;
      side_r[0] <= a_side_r;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k][CW-1]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - cobo_pkg::atan_q30(k);
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + cobo_pkg::atan_q30(k);
        end
        q_r[k+1]    <= q_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // Round to Q24 and put the quarter turn back.
  logic signed [CW-1:0]              x_rnd;
  logic signed [CW-1:0]              y_rnd;
  logic signed [cobo_pkg::CS_W-1:0]  xc;
  logic signed [cobo_pkg::CS_W-1:0]  yc;
  logic signed [cobo_pkg::CS_W-1:0]  c_nxt;
  logic signed [cobo_pkg::CS_W-1:0]  s_nxt;
  logic                              r_v_r;
  logic signed [cobo_pkg::CS_W-1:0]  c_r;
  logic signed [cobo_pkg::CS_W-1:0]  s_r;
  logic [SIDE_W-1:0]                 r_side_r;

  assign x_rnd = (x_r[NS] + CW'(32)) >>> 6;
  assign y_rnd = (y_r[NS] + CW'(32)) >>> 6;
  assign xc    = x_rnd[cobo_pkg::CS_W-1:0];
  assign yc    = y_rnd[cobo_pkg::CS_W-1:0];

  always_comb begin
    case (q_r[NS])
      2'd0: begin
        c_nxt = xc;
        s_nxt = yc;
      end
      2'd1: begin
        c_nxt = -yc;
        s_nxt = xc;
      end
      2'd2: begin
        c_nxt = -xc;
        s_nxt = -yc;
      end
      default: begin
        c_nxt = yc;
        s_nxt = -xc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (en) begin
      r_v_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r      <= c_nxt;
      s_r      <= s_nxt;
      r_side_r <= side_r[NS];
    end
  end

  assign out_valid = r_v_r;
  assign cos_q     = c_r;
  assign sin_q     = s_r;
  assign side_out  = r_side_r;

endmodule

@@ rtl/core/cobo_test.sv @@
`timescale 1ns / 1ps

module cobo_test #(
  parameter int COORD_BITS = cobo_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [COORD_BITS-1:0]     circle_x,
  input  logic signed [COORD_BITS-1:0]     circle_y,
  input  logic [COORD_BITS-2:0]            circle_radius,
  input  logic signed [COORD_BITS-1:0]     box_x,
  input  logic signed [COORD_BITS-1:0]     box_y,
  input  logic [COORD_BITS-2:0]            half_length,
  input  logic [COORD_BITS-2:0]            half_width,
  input  logic signed [cobo_pkg::CS_W-1:0] cos_q,
  input  logic signed [cobo_pkg::CS_W-1:0] sin_q,
  input  logic [15:0]                      distance_bias,
  output logic                             out_valid,
  output logic                             overlaps
);

  localparam int CSW = cobo_pkg::CS_W;
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = DW + CSW;
  localparam int PJW = PW + 1 - 24;
  localparam int EW  = PJW + 1;
  localparam int ET  = (EW - 1 < 31) ? EW - 1 : 31;
  localparam int RW  = COORD_BITS - 1;

  // Stage 1: offset of the circle from the box center.
  logic                  v1_r;
  logic signed [DW-1:0]  dx_r;
  logic signed [DW-1:0]  dy_r;
  logic signed [CSW-1:0] c1_r;
  logic signed [CSW-1:0] s1_r;
  logic [RW-1:0]         rad1_r;
  logic [RW-1:0]         hl1_r;
  logic [RW-1:0]         hw1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= DW'(circle_x) - DW'(box_x);
      dy_r   <= DW'(circle_y) - DW'(box_y);
      c1_r   <= cos_q;
      s1_r   <= sin_q;
      rad1_r <= circle_radius;
      hl1_r  <= half_length;
      hw1_r  <= half_width;
    end
  end

  // Stage 2: the four products of the rotation.
  logic                 v2_r;
  logic signed [PW-1:0] m_xc_r;
  logic signed [PW-1:0] m_ys_r;
  logic signed [PW-1:0] m_yc_r;
  logic signed [PW-1:0] m_xs_r;
  logic [RW-1:0]        rad2_r;
  logic [RW-1:0]        hl2_r;
  logic [RW-1:0]        hw2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_xc_r <= dx_r * c1_r;
      m_ys_r <= dy_r * s1_r;
      m_yc_r <= dy_r * c1_r;
      m_xs_r <= dx_r * s1_r;
      rad2_r <= rad1_r;
      hl2_r  <= hl1_r;
      hw2_r  <= hw1_r;
    end
  end

  // Stage 3: projections rounded back to coordinate LSBs.
  logic signed [PW:0]    sum0;
  logic signed [PW:0]    sum1;
  logic signed [PW:0]    sh0;
  logic signed [PW:0]    sh1;
  logic                  v3_r;
  logic signed [PJW-1:0] p0_r;
  logic signed [PJW-1:0] p1_r;
  logic [RW-1:0]         rad3_r;
  logic [RW-1:0]         hl3_r;
  logic [RW-1:0]         hw3_r;

  assign sum0 = (PW+1)'(m_xc_r) + (PW+1)'(m_ys_r) + (PW+1)'(25'sh80_0000);
  assign sum1 = (PW+1)'(m_yc_r) - (PW+1)'(m_xs_r) + (PW+1)'(25'sh80_0000);
  assign sh0  = sum0 >>> 24;
  assign sh1  = sum1 >>> 24;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r   <= sh0[PJW-1:0];
      p1_r   <= sh1[PJW-1:0];
      rad3_r <= rad2_r;
      hl3_r  <= hl2_r;
      hw3_r  <= hw2_r;
    end
  end

  // Stage 4: excess of each projection over its half extent.
  logic [PJW-1:0]       mag0;
  logic [PJW-1:0]       mag1;
  logic signed [EW-1:0] ex0;
  logic signed [EW-1:0] ex1;
  logic                 v4_r;
  logic [ET-1:0]        e0_r;
  logic [ET-1:0]        e1_r;
  logic                 pos0_r;
  logic                 pos1_r;
  logic                 sat0_r;
  logic                 sat1_r;
  logic [RW-1:0]        rad4_r;

  assign mag0 = p0_r[PJW-1] ? PJW'(-p0_r) : PJW'(p0_r);
  assign mag1 = p1_r[PJW-1] ? PJW'(-p1_r) : PJW'(p1_r);
  assign ex0  = $signed({1'b0, mag0}) - $signed(EW'(hl3_r));
  assign ex1  = $signed({1'b0, mag1}) - $signed(EW'(hw3_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_r   <= ex0[ET-1:0];
      e1_r   <= ex1[ET-1:0];
      pos0_r <= !ex0[EW-1] && (ex0 != '0);
      pos1_r <= !ex1[EW-1] && (ex1 != '0);
      sat0_r <= 64'(ex0) >= 64'sd2147483648;
      sat1_r <= 64'(ex1) >= 64'sd2147483648;
      rad4_r <= rad3_r;
    end
  end

  // Stage 5: saturated squares and the squared radius.
  logic [2*ET-1:0] prod0;
  logic [2*ET-1:0] prod1;
  logic [2*RW-1:0] rad_sq;
  logic            v5_r;
  logic [63:0]     sq0_r;
  logic [63:0]     sq1_r;
  logic [2*RW-1:0] r2_5_r;

  assign prod0  = e0_r * e0_r;
  assign prod1  = e1_r * e1_r;
  assign rad_sq = rad4_r * rad4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r  <= !pos0_r ? 64'd0 : (sat0_r ? cobo_pkg::SQ_SAT : 64'(prod0));
      sq1_r  <= !pos1_r ? 64'd0 : (sat1_r ? cobo_pkg::SQ_SAT : 64'(prod1));
      r2_5_r <= rad_sq;
    end
  end

  // Stage 6: bias plus the first square.
  logic [63:0]     acc0;
  logic            v6_r;
  logic [63:0]     acc_r;
  logic [63:0]     sq1_6_r;
  logic [2*RW-1:0] r2_6_r;

  assign acc0 = 64'(distance_bias) + sq0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r   <= (acc0 > cobo_pkg::SQ_SAT) ? cobo_pkg::SQ_SAT : acc0;
      sq1_6_r <= sq1_r;
      r2_6_r  <= r2_5_r;
    end
  end

  // Stage 7: second square and the final compare; touching counts as overlap.
  logic [63:0] acc1;
  logic [63:0] acc1_sat;
  logic        v7_r;
  logic        ov_r;

  assign acc1     = acc_r + sq1_6_r;
  assign acc1_sat = (acc1 > cobo_pkg::SQ_SAT) ? cobo_pkg::SQ_SAT : acc1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ov_r <= acc1_sat <= 64'(r2_6_r);
    end
  end

  assign out_valid = v7_r;
  assign overlaps  = ov_r;

endmodule

@@ rtl/core/circle_oriented_box_overlap.sv @@
`timescale 1ns / 1ps

// Circle versus rotated rectangle overlap test, fully pipelined: one item is
// accepted per clock while in_tready is high, and every item yields exactly
// one result item. Each item passes the angle reduction and radian conversion
// registers, a CORDIC stage for each iteration up to the arctangent table
// size, the cos/sin rounding register, the projection, squaring and compare
// stages, and the output register. A two-entry output buffer keeps in_tready
// high while a result waits; it drops only when both entries are full. The
// distance bias register sits at byte address 0 of the configuration port
// and should be written only while no items are in flight.
module circle_oriented_box_overlap #(
  parameter int COORD_BITS   = cobo_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS   = cobo_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = cobo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // circle_x, circle_y, circle_radius, box_x, box_y, half_length, half_width,
  // heading, zero padding
  input  logic [((7*COORD_BITS-3+ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // overlaps, zero padding
  output logic [7:0]                      out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cobo_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int CB     = COORD_BITS;
  localparam int SIDE_W = 4*CB + 3*(CB-1);

  // Configuration register.
  logic [15:0] bias_r;
  logic        cfg_wr;
  logic        cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[cobo_pkg::CFG_ADDR_W-1] == cobo_pkg::CFG_REG_DISTANCE_BIAS;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_hit;
  assign cfg_prdata = cfg_hit ? {16'd0, bias_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (cfg_wr) begin
      bias_r <= cfg_pwdata[15:0];
    end
  end

  // Pipeline advances whenever the output buffer has a free entry.
  logic skid_v_r;
  logic en;

  assign en        = !skid_v_r;
  assign in_tready = en;

  logic [SIDE_W-1:0] side_in;
  logic [SIDE_W-1:0] side_out;
  logic              sc_v;
  logic signed [cobo_pkg::CS_W-1:0] cos_q;
  logic signed [cobo_pkg::CS_W-1:0] sin_q;

  assign side_in = in_tdata[SIDE_W-1:0];

  cobo_sincos #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS),
    .SIDE_W      (SIDE_W)
  ) u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .heading  (in_tdata[SIDE_W +: ANGLE_BITS]),
    .side_in  (side_in),
    .out_valid(sc_v),
    .cos_q    (cos_q),
    .sin_q    (sin_q),
    .side_out (side_out)
  );

  logic pipe_v;
  logic pipe_ov;

  cobo_test #(
    .COORD_BITS(COORD_BITS)
  ) u_test (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (sc_v),
    .circle_x     ($signed(side_out[0 +: CB])),
    .circle_y     ($signed(side_out[CB +: CB])),
    .circle_radius(side_out[2*CB +: CB-1]),
    .box_x        ($signed(side_out[3*CB-1 +: CB])),
    .box_y        ($signed(side_out[4*CB-1 +: CB])),
    .half_length  (side_out[5*CB-1 +: CB-1]),
    .half_width   (side_out[6*CB-2 +: CB-1]),
    .cos_q        (cos_q),
    .sin_q        (sin_q),
    .distance_bias(bias_r),
    .out_valid    (pipe_v),
    .overlaps     (pipe_ov)
  );

  // Output register with a one-entry skid behind it.
  logic out_v_r;
  logic out_d_r;
  logic skid_d_r;
  logic pipe_take;
  logic out_fire;

  assign pipe_take = pipe_v && en;
  assign out_fire  = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_fire) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (pipe_take) begin
        if (out_v_r && !out_tready) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_d_r <= skid_d_r;
      end
    end else if (pipe_take) begin
      if (out_v_r && !out_tready) begin
        skid_d_r <= pipe_ov;
      end else begin
        out_d_r <= pipe_ov;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_d_r};

endmodule
